/* src/brm_pkg.sv */
// shared constants, types and helpers for the bitmap run allocator
package brm_pkg;

   localparam int WORD_WIDTH     = 32;
   localparam int BITS_PER_BLOCK = 1024;
   localparam int MAX_BITS       = 16384;
   localparam int NWORDS         = MAX_BITS / WORD_WIDTH;
   localparam int OW             = $clog2(WORD_WIDTH);
   localparam int AW             = $clog2(NWORDS);
   localparam int BW             = $clog2(BITS_PER_BLOCK);
   localparam int PW             = 15;
   localparam int SW             = 14;
   localparam int CW             = 15;

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic [PW-1:0]         pos_type;
   typedef logic [OW:0]           span_type;

   typedef struct packed {
      logic          hit;
      logic [OW-1:0] hit_idx;
      span_type      take;
      word_type      set_mask;
      logic          to_end;
   } scan_type;

   // bits lo <= i < hi set
   function automatic word_type range_mask(input span_type lo, input span_type hi);
      word_type m;
      m = '0;
      for (int i = 0; i < WORD_WIDTH; i++) begin
         m[i] = (span_type'(i) >= lo) && (span_type'(i) < hi);
      end
      return m;
   endfunction

endpackage

/* src/brm_ram.sv */
// bitmap word memory, one write and one registered read port
module brm_ram (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [brm_pkg::AW-1:0] wr_addr,
   input  brm_pkg::word_type      wr_data,
   input  logic                   rd_en,
   input  logic [brm_pkg::AW-1:0] rd_addr,
   output brm_pkg::word_type      rd_data
);
   import brm_pkg::*;

   word_type mem [NWORDS];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* src/brm_scan.sv */
// per-word search for a free bit and extent of a free run
module brm_scan (
   input  brm_pkg::word_type      data,
   input  logic [brm_pkg::OW-1:0] offset,
   input  brm_pkg::span_type      bound,
   input  logic [brm_pkg::CW-1:0] remain,
   output brm_pkg::scan_type      res
);
   import brm_pkg::*;

   word_type cand;
   word_type blocked;
   span_type off_w;
   span_type e;
   span_type n;
   span_type take;
   logic     found_c;
   logic     found_b;
   logic [OW-1:0] idx;

   always_comb begin
      off_w = {1'b0, offset};
      for (int i = 0; i < WORD_WIDTH; i++) begin
         cand[i]    = ~data[i] && (span_type'(i) >= off_w) && (span_type'(i) < bound);
         blocked[i] = (data[i] || (span_type'(i) >= bound)) && (span_type'(i) >= off_w);
      end
      found_c = 1'b0;
      idx     = '0;
      found_b = 1'b0;
      e       = span_type'(WORD_WIDTH);
      for (int i = 0; i < WORD_WIDTH; i++) begin
         if (cand[i] && !found_c) begin
            found_c = 1'b1;
            idx     = OW'(i);
         end
         if (blocked[i] && !found_b) begin
            found_b = 1'b1;
            e       = span_type'(i);
         end
      end
      n    = e - off_w;
      take = (remain < CW'(n)) ? remain[OW:0] : n;
      res.hit      = found_c;
      res.hit_idx  = idx;
      res.take     = take;
      res.set_mask = range_mask(off_w, off_w + take);
      res.to_end   = !found_b && (take == n);
   end
endmodule

/* src/bitmap_run_allocator_top.sv */
// top level: request sequencer around the bitmap memory
// first-fit bitmap allocator. after reset the bitmap is swept to all free, one
// word per cycle with busy high. a transfer is taken when start is high and
// busy low; the one result comes back on a single-cycle rsp_valid strobe and
// cannot be held off. an allocate scans one word per cycle from the hint,
// rereads the word holding the first free bit, then marks one word per cycle;
// a free clears the words of its range in turn; an allocate of zero or with
// no room past the hint, and an empty free range, answer from idle without a
// memory access. the single memory read port sets the pace. csr writes load
// total_bits, reload the free counter, clear the hint
module bitmap_run_allocator_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_mode,
   input  logic [brm_pkg::SW-1:0] req_start_req,
   input  logic [brm_pkg::CW-1:0] req_count,
   output logic                   rsp_valid,
   output logic [brm_pkg::SW-1:0] rsp_run_start,
   output logic [brm_pkg::CW-1:0] rsp_granted,
   output logic [brm_pkg::CW-1:0] rsp_free_left,
   input  logic                   csr_wr_en,
   input  logic [brm_pkg::CW-1:0] csr_wr_data
);
   import brm_pkg::*;

   typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_SRCH, ST_RUN, ST_FREE} state_type;

   state_type state_ff, state_in;
   logic [AW:0] clr_ff, clr_in;
   pos_type     total_ff, total_in;
   pos_type     hint_ff, hint_in;
   pos_type     free_ff, free_in;
   pos_type     p_ff, p_in;
   pos_type     stop_ff, stop_in;
   pos_type     cnt_ff, cnt_in;
   pos_type     got_ff, got_in;
   pos_type     rstart_ff, rstart_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_run_start_ff, rsp_run_start_in;
   logic [CW-1:0] rsp_granted_ff, rsp_granted_in;
   logic [CW-1:0] rsp_free_left_ff, rsp_free_left_in;

   // memory port
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   word_type      wr_data, rd_data;

   scan_type  scan;
   pos_type   lim, wbase, bound_src, diff, nxt, pos, got_new, p_new;
   pos_type   end_c, fsum_c, stop_c;
   logic [PW:0] end_sum, fsum, blk_end;
   span_type  bound;

   brm_ram u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   brm_scan u_scan (
      .data  (rd_data),
      .offset(p_ff[OW-1:0]),
      .bound (bound),
      .remain(cnt_ff - got_ff),
      .res   (scan)
   );

   always_comb begin
      lim   = (total_ff > pos_type'(MAX_BITS)) ? pos_type'(MAX_BITS) : total_ff;
      wbase = {p_ff[PW-1:OW], {OW{1'b0}}};
      case (state_ff)
         ST_RUN:  bound_src = stop_ff;
         ST_FREE: bound_src = stop_ff;
         default: bound_src = lim;
      endcase
      diff    = bound_src - wbase;
      bound   = (diff >= pos_type'(WORD_WIDTH)) ? span_type'(WORD_WIDTH) : diff[OW:0];
      nxt     = wbase + pos_type'(WORD_WIDTH);
      pos     = wbase + pos_type'(scan.hit_idx);
      blk_end = ({{(BW+1){1'b0}}, pos[PW-1:BW]} + (PW+1)'(1)) << BW;
      stop_c  = (blk_end < {1'b0, lim}) ? blk_end[PW-1:0] : lim;
      got_new = got_ff + pos_type'(scan.take);
      p_new   = p_ff + pos_type'(scan.take);
      end_sum = {2'b0, req_start_req} + {1'b0, req_count};
      end_c   = (end_sum < {1'b0, lim}) ? end_sum[PW-1:0] : lim;
      fsum    = {1'b0, free_ff} + {1'b0, req_count};
      fsum_c  = (fsum > {1'b0, lim}) ? lim : fsum[PW-1:0];

      state_in         = state_ff;
      clr_in           = clr_ff;
      total_in         = total_ff;
      hint_in          = hint_ff;
      free_in          = free_ff;
      p_in             = p_ff;
      stop_in          = stop_ff;
      cnt_in           = cnt_ff;
      got_in           = got_ff;
      rstart_in        = rstart_ff;
      rsp_valid_in     = 1'b0;
      rsp_run_start_in = rsp_run_start_ff;
      rsp_granted_in   = rsp_granted_ff;
      rsp_free_left_in = rsp_free_left_ff;
      wr_en   = 1'b0;
      wr_addr = p_ff[PW-2:OW];
      wr_data = '0;
      rd_en   = 1'b0;
      rd_addr = p_ff[PW-2:OW];

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff[AW-1:0];
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(NWORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cnt_in = req_count;
               got_in = '0;
               if (!req_mode) begin
                  if (req_count == '0 || hint_ff >= lim) begin
                     rsp_valid_in     = 1'b1;
                     rsp_run_start_in = '0;
                     rsp_granted_in   = '0;
                     rsp_free_left_in = free_ff;
                  end else begin
                     p_in     = hint_ff;
                     rd_en    = 1'b1;
                     rd_addr  = hint_ff[PW-2:OW];
                     state_in = ST_SRCH;
                  end
               end else begin
                  // counter and hint move at once, bits are cleared word by word
                  hint_in = ({1'b0, req_start_req} < hint_ff) ? {1'b0, req_start_req}
                                                              : hint_ff;
                  free_in = fsum_c;
                  if ({1'b0, req_start_req} >= end_c) begin
                     rsp_valid_in     = 1'b1;
                     rsp_run_start_in = '0;
                     rsp_granted_in   = '0;
                     rsp_free_left_in = fsum_c;
                  end else begin
                     p_in     = {1'b0, req_start_req};
                     stop_in  = end_c;
                     rd_en    = 1'b1;
                     rd_addr  = req_start_req[SW-1:OW];
                     state_in = ST_FREE;
                  end
               end
            end
         end
         ST_SRCH: begin
            if (scan.hit) begin
               // reread the same word to start marking
               rstart_in = pos;
               p_in      = pos;
               stop_in   = stop_c;
               rd_en     = 1'b1;
               state_in  = ST_RUN;
            end else if (nxt >= lim) begin
               rsp_valid_in     = 1'b1;
               rsp_run_start_in = '0;
               rsp_granted_in   = '0;
               rsp_free_left_in = free_ff;
               state_in         = ST_IDLE;
            end else begin
               p_in    = nxt;
               rd_en   = 1'b1;
               rd_addr = nxt[PW-2:OW];
            end
         end
         ST_RUN: begin
            wr_en   = 1'b1;
            wr_data = rd_data | scan.set_mask;
            got_in  = got_new;
            p_in    = p_new;
            if (scan.to_end && got_new < cnt_ff && p_new < stop_ff) begin
               rd_en   = 1'b1;
               rd_addr = p_new[PW-2:OW];
            end else begin
               hint_in          = p_new;
               free_in          = (free_ff >= got_new) ? free_ff - got_new : '0;
               rsp_valid_in     = 1'b1;
               rsp_run_start_in = rstart_ff[SW-1:0];
               rsp_granted_in   = got_new;
               rsp_free_left_in = (free_ff >= got_new) ? free_ff - got_new : '0;
               state_in         = ST_IDLE;
            end
         end
         ST_FREE: begin
            wr_en   = 1'b1;
            wr_data = rd_data & ~range_mask({1'b0, p_ff[OW-1:0]}, bound);
            if (nxt < stop_ff) begin
               p_in    = nxt;
               rd_en   = 1'b1;
               rd_addr = nxt[PW-2:OW];
            end else begin
               rsp_valid_in     = 1'b1;
               rsp_run_start_in = '0;
               rsp_granted_in   = '0;
               rsp_free_left_in = free_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         total_in = csr_wr_data;
         free_in  = (csr_wr_data > pos_type'(MAX_BITS)) ? pos_type'(MAX_BITS) : csr_wr_data;
         hint_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         total_ff     <= pos_type'(MAX_BITS);
         hint_ff      <= '0;
         free_ff      <= pos_type'(MAX_BITS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         hint_ff      <= hint_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff             <= p_in;
      stop_ff          <= stop_in;
      cnt_ff           <= cnt_in;
      got_ff           <= got_in;
      rstart_ff        <= rstart_in;
      rsp_run_start_ff <= rsp_run_start_in;
      rsp_granted_ff   <= rsp_granted_in;
      rsp_free_left_ff <= rsp_free_left_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_run_start = rsp_run_start_ff;
   assign rsp_granted   = rsp_granted_ff;
   assign rsp_free_left = rsp_free_left_ff;
endmodule
